>>> sv/rhd2_pkg.sv
// Shared types, constants and lane arithmetic for the 2x2 RGBA downsampler.
`default_nettype none

package rhd2_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned N_CHAN  = 4;
  localparam int unsigned LANE_W  = CHAN_W + 1;
  localparam int unsigned PIX_W   = CHAN_W * N_CHAN;
  localparam int unsigned PAIR_W  = LANE_W * N_CHAN;
  localparam int unsigned SIDE_W  = 10;

  // Register map: register index taken from paddr[2].
  localparam logic REG_OUT_SIDE = 1'b0;
  localparam logic [SIDE_W-1:0] OUT_SIDE_RESET = SIDE_W'(512);

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [PAIR_W-1:0] pair_t;

  // Sum two pixels channel by channel into 9-bit lanes.
  function automatic pair_t add_pair(pix_t a, pix_t b);
    pair_t r;
    r = '0;
    for (int c = 0; c < N_CHAN; c++) begin
      r[c*LANE_W +: LANE_W] = LANE_W'(a[c*CHAN_W +: CHAN_W]) + LANE_W'(b[c*CHAN_W +: CHAN_W]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/rhd2_line_mem.sv
// Line store of pair sums: one write port, one registered read port.
`default_nettype none

module rhd2_line_mem
  import rhd2_pkg::*;
#(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire pair_t         wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output      pair_t         rdata_o
);

  pair_t mem_q [DEPTH];
  pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/rgba_half_downsample_2x2.sv
// Top level of the 2x2 box-filter downsampler for RGBA8 pixel streams.
//
// Source pixels of a square image, side 2*out_side, arrive in raster order on
// the slave stream, one transfer per clock at full rate. Each 2x2 block gives
// one output pixel whose channels are floor(sum/4) of the block's bytes; the
// result is issued on the bottom-right pixel of the block, and tlast marks the
// image's last output. The block takes one pixel every cycle while the output is not
// held; after the transfer that completes its block, a result is registered in stage 1
// together with the line store read, then in the output register.
// Even source rows write horizontal pair sums into the line store; odd rows read
// the pair above and add. The line store needs no clearing pass after reset.
// out_side is written over the APB port at address 0 (0 acts as 1, values above
// MAX_OUT_SIDE act as MAX_OUT_SIDE) and should change only while the stream is
// idle. Backpressure on the master side stalls the slave side only when a
// result is held and the next result is ready behind it.
`default_nettype none

module rgba_half_downsample_2x2
  import rhd2_pkg::*;
#(
  parameter int unsigned MAX_OUT_SIDE = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  // Source pixels
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // chan0, chan1, chan2, chan3 from bit 0
  // Downsampled pixels
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [31:0] m_axis_tdata_o,   // avg0, avg1, avg2, avg3 from bit 0
  output      logic        m_axis_tlast_o    // image_end
);

  localparam int unsigned AW    = (MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE) : 1;
  localparam int unsigned SW_MX = $clog2(MAX_OUT_SIDE + 1);
  localparam int unsigned SW    = (SW_MX > SIDE_W) ? SW_MX : SIDE_W;
  localparam logic [SW-1:0] MAX_SIDE = SW'(MAX_OUT_SIDE);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [SIDE_W-1:0] out_side_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_OUT_SIDE);
  assign prdata = (paddr[2] == REG_OUT_SIDE) ? 32'(out_side_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_side_q <= OUT_SIDE_RESET;
    end else if (cfg_wr) begin
      out_side_q <= pwdata[SIDE_W-1:0];
    end
  end

  // Effective side, clamped to 1..MAX_OUT_SIDE; compare against side - 1.
  logic [SW-1:0] side_raw;
  logic [SW-1:0] side_eff;
  logic [SW-1:0] side_m1;

  always_comb begin
    side_raw = SW'(out_side_q);
    if (side_raw == '0) begin
      side_eff = SW'(1);
    end else if (side_raw > MAX_SIDE) begin
      side_eff = MAX_SIDE;
    end else begin
      side_eff = side_raw;
    end
    side_m1 = side_eff - SW'(1);
  end

  // ---------------------------------------------------------------------------
  // Position counters and left pixel of the current pair
  // ---------------------------------------------------------------------------
  logic [SIDE_W-1:0] col_cnt_q, col_cnt_d;
  logic [SIDE_W-1:0] row_cnt_q, row_cnt_d;
  logic              col_odd_q, col_odd_d;
  logic              row_odd_q, row_odd_d;
  pix_t              left_q;

  logic  in_xfer;
  logic  last_col;
  logic  last_row;
  pair_t pair_sum;
  logic [AW-1:0] line_addr;

  assign in_xfer   = s_axis_tvalid_i & s_axis_tready_o;
  assign last_col  = SW'(col_cnt_q) >= side_m1;
  assign last_row  = SW'(row_cnt_q) >= side_m1;
  assign pair_sum  = add_pair(left_q, s_axis_tdata_i);
  // The column counter never passes MAX_OUT_SIDE - 1, so it addresses directly.
  assign line_addr = AW'(col_cnt_q);

  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    col_odd_d = col_odd_q;
    row_odd_d = row_odd_q;
    if (in_xfer) begin
      if (!col_odd_q) begin
        col_odd_d = 1'b1;
      end else begin
        col_odd_d = 1'b0;
        if (last_col) begin
          col_cnt_d = '0;
          if (!row_odd_q) begin
            row_odd_d = 1'b1;
          end else begin
            row_odd_d = 1'b0;
            // Wrap the row counter at the last row: the next pixel opens a new image.
            row_cnt_d = last_row ? '0 : row_cnt_q + SIDE_W'(1);
          end
        end else begin
          col_cnt_d = col_cnt_q + SIDE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      col_odd_q <= 1'b0;
      row_odd_q <= 1'b0;
      left_q    <= '0;
    end else begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      col_odd_q <= col_odd_d;
      row_odd_q <= row_odd_d;
      if (in_xfer && !col_odd_q) begin
        left_q <= s_axis_tdata_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: even rows write the pair sum, odd rows read the pair above.
  // A read of an entry always trails its write by at least one row, so the
  // two ports never collide on one entry in the same cycle.
  // ---------------------------------------------------------------------------
  logic  line_we;
  logic  line_re;
  pair_t above;

  assign line_we = in_xfer & col_odd_q & ~row_odd_q;
  assign line_re = in_xfer & col_odd_q &  row_odd_q;

  rhd2_line_mem #(
    .DEPTH (MAX_OUT_SIDE),
    .AW    (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_addr),
    .wdata_i (pair_sum),
    .re_i    (line_re),
    .raddr_i (line_addr),
    .rdata_o (above)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: wait for the line read; hold the lower pair and the end flag.
  // ---------------------------------------------------------------------------
  logic  s1_valid_q;
  pair_t s1_pair_q;
  logic  s1_end_q;
  logic  out_free;
  logic  s1_adv;

  assign out_free        = ~m_axis_tvalid_o | m_axis_tready_i;
  assign s1_adv          = s1_valid_q & out_free;
  // Take a pixel unless stage 1 holds a result that cannot move on.
  assign s_axis_tready_o = ~s1_valid_q | out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (line_re) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_re) begin
      s1_pair_q <= pair_sum;
      s1_end_q  <= last_col & last_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: add the pair above, divide by four.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]  avg_d;
  logic [PIX_W-1:0]  avg_q;
  logic              end_q;
  logic              out_valid_q;
  logic [LANE_W:0]   lane_sum;

  always_comb begin
    avg_d    = '0;
    lane_sum = '0;
    for (int c = 0; c < N_CHAN; c++) begin
      lane_sum = (LANE_W+1)'(above[c*LANE_W +: LANE_W])
               + (LANE_W+1)'(s1_pair_q[c*LANE_W +: LANE_W]);
      avg_d[c*CHAN_W +: CHAN_W] = lane_sum[LANE_W:2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      avg_q <= avg_d;
      end_q <= s1_end_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = avg_q;
  assign m_axis_tlast_o  = end_q;

endmodule

`default_nettype wire

>>> tb/rgba_half_downsample_2x2_chk.sv
// Scoreboard for the 2x2 RGBA downsampler: predicts each output pixel and compares it.
`timescale 1ns / 100ps

module rgba_half_downsample_2x2_chk
  import rhd2_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic [31:0] prdata_i,
  input  logic        pready_i,
  input  logic        src_valid_i,
  input  logic        src_ready_i,
  input  logic [31:0] src_data_i,   // chan0, chan1, chan2, chan3 from bit 0
  input  logic        dst_valid_i,
  input  logic        dst_ready_i,
  input  logic [31:0] dst_data_i,   // avg0, avg1, avg2, avg3 from bit 0
  input  logic        dst_last_i,   // image_end
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    logic        image_end;
    logic [31:0] avgs;
  } out_px_t;

  logic [35:0] line_sums [MAX_SIDE];
  logic [31:0] left_px;
  logic [9:0]  side_reg;
  logic [9:0]  col_cnt;
  logic [9:0]  row_cnt;
  logic        col_phase;
  logic        row_phase;
  out_px_t     awaited_px [$];
  int          fails;
  int          checked;

  always @(posedge clk_i or negedge rst_ni) begin
    out_px_t     want;
    logic [35:0] pair;
    logic [35:0] above;
    logic [9:0]  total;
    int          side_eff;
    logic        last_col;
    logic        last_row;
    if (!rst_ni) begin
      side_reg  = OUT_SIDE_RESET;
      left_px   = '0;
      col_cnt   = '0;
      row_cnt   = '0;
      col_phase = 1'b0;
      row_phase = 1'b0;
      awaited_px.delete();
      fails     = 0;
      checked   = 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i[2] == REG_OUT_SIDE) begin
        if (pwrite_i) begin
          side_reg = pwdata_i[9:0];
        end else if (prdata_i !== {22'b0, side_reg}) begin
          fails++;
          $display("%0t: out_side read back: expected %0d, got %0d", $time, side_reg, prdata_i);
        end
      end

      // outputs first: a result at this edge stems from earlier transfers
      if (dst_valid_i && dst_ready_i) begin
        if (awaited_px.size() == 0) begin
          fails++;
          $display("%0t: output pixel %h (last %b) with none expected: expected nothing, got %h",
                   $time, dst_data_i, dst_last_i, dst_data_i);
        end else begin
          want = awaited_px.pop_front();
          checked++;
          for (int c = 0; c < 4; c++) begin
            if (dst_data_i[8*c +: 8] !== want.avgs[8*c +: 8]) begin
              fails++;
              $display("%0t: avg%0d: expected %h, got %h", $time, c,
                       want.avgs[8*c +: 8], dst_data_i[8*c +: 8]);
            end
          end
          if (dst_last_i !== want.image_end) begin
            fails++;
            $display("%0t: image_end: expected %b, got %b", $time, want.image_end, dst_last_i);
          end
        end
      end

      if (src_valid_i && src_ready_i) begin
        if (!col_phase) begin
          left_px   = src_data_i;
          col_phase = 1'b1;
        end else begin
          side_eff = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : int'(side_reg));
          last_col = int'(col_cnt) >= side_eff - 1;
          last_row = int'(row_cnt) >= side_eff - 1;
          for (int c = 0; c < 4; c++) begin
            pair[9*c +: 9] = {1'b0, left_px[8*c +: 8]} + {1'b0, src_data_i[8*c +: 8]};
          end
          if (!row_phase) begin
            line_sums[col_cnt % MAX_SIDE] = pair;
          end else begin
            above = line_sums[col_cnt % MAX_SIDE];
            for (int c = 0; c < 4; c++) begin
              total = {1'b0, above[9*c +: 9]} + {1'b0, pair[9*c +: 9]};
              want.avgs[8*c +: 8] = total[9:2];
            end
            want.image_end = last_col && last_row;
            awaited_px.push_back(want);
          end
          col_phase = 1'b0;
          // wrap the column at the last pair; rows advance after each odd source row
          if (last_col) begin
            col_cnt = '0;
            if (!row_phase) begin
              row_phase = 1'b1;
            end else begin
              row_phase = 1'b0;
              row_cnt   = last_row ? '0 : row_cnt + 10'd1;
            end
          end else begin
            col_cnt = col_cnt + 10'd1;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= awaited_px.size();
    checked_o    <= checked;
  end

endmodule

>>> tb/rgba_half_downsample_2x2_tb.sv
// Stimulus and verdict for the 2x2 RGBA downsampler regression.
`timescale 1ns / 100ps

module rgba_half_downsample_2x2_tb;
  import rhd2_pkg::*;

  localparam logic [2:0] ADDR_OUT_SIDE = {REG_OUT_SIDE, 2'b00};
  localparam int RANDOM_PX     = 1250;
  localparam int SETTLE_CYCLES = 6;     // output register plus line store read, with margin
  localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer before giving up

  logic        clk;
  logic        rst_n    = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_valid  = 1'b0;
  logic        s_ready;
  logic [31:0] s_data   = '0;
  logic        m_valid;
  logic        m_ready  = 1'b0;
  logic [31:0] m_data;
  logic        m_last;

  // no idling on either side while calm is set
  logic        calm     = 1'b0;
  int          sent_px;
  int          directed_px;
  int          images;
  int          quiet_cycles;
  int          fail_count;
  int          pending;
  int          checked;

  rgba_half_downsample_2x2 uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  rgba_half_downsample_2x2_chk chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .src_valid_i  (s_valid),
    .src_ready_i  (s_ready),
    .src_data_i   (s_data),
    .dst_valid_i  (m_valid),
    .dst_ready_i  (m_ready),
    .dst_data_i   (m_data),
    .dst_last_i   (m_last),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Downstream stall pattern: drop tready about 16 percent of the time.
  always @(posedge clk) begin
    m_ready <= calm || ($urandom_range(0, 99) >= 16);
  end

  // Watchdog: end the run if nothing moves on either stream for too long.
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending);
      $display("rgba_half_downsample_2x2 regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One APB access (setup then access phase), followed by an idle step with psel low so
  // that back-to-back accesses never drive psel twice in one step.
  task automatic apb_access(input logic wr, input logic [9:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_OUT_SIDE;
    pwdata  <= {22'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write the side, then read it straight back.
  task automatic set_side(input logic [9:0] value);
    apb_access(1'b1, value);
    apb_access(1'b0, '0);
  endtask

  // Present one source pixel and hold it until the transfer completes.
  // Valid is only lowered for a random gap, never lowered and raised in one step.
  task automatic push_pixel(input logic [31:0] px);
    if (!calm && $urandom_range(0, 99) < 19) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= px;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sent_px++;
    calm <= (sent_px >= 500 && sent_px < 800);
  endtask

  // Random pixels, biased so that channels hit 00 and FF often.
  task automatic send_pixels(input int count);
    logic [31:0] px;
    int          pick;
    repeat (count) begin
      for (int c = 0; c < 4; c++) begin
        pick = $urandom_range(0, 7);
        px[8*c +: 8] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      end
      push_pixel(px);
    end
  endtask

  // Drop valid, wait until every predicted result has left, then let the
  // pipeline run dry before touching the register.
  task automatic settle();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixels still needed to close the image when the side shrinks from old_side to
  // new_side after `done` pixels. Shrinking never makes an odd row read a line
  // store entry that the even row above has not written.
  function automatic int pixels_to_close(int done, int old_side, int new_side);
    int src;
    int col;
    int row;
    int col_odd;
    int row_odd;
    int needed;
    src     = 2 * old_side;
    row_odd = (done / src) % 2;
    row     = (done / src) / 2;
    col_odd = (done % src) % 2;
    col     = (done % src) / 2;
    needed  = 0;
    forever begin
      needed++;
      if (col_odd == 0) begin
        col_odd = 1;
      end else begin
        col_odd = 0;
        if (col >= new_side - 1) begin
          col = 0;
          if (row_odd == 0) begin
            row_odd = 1;
          end else begin
            row_odd = 0;
            if (row >= new_side - 1) return needed;
            row++;
          end
        end else begin
          col++;
        end
      end
    end
  endfunction

  initial begin
    int          side;
    int          shrunk;
    int          total;
    int          done;
    logic [9:0]  wr_side;
    sent_px      = 0;
    images       = 0;
    quiet_cycles = 0;

    // hold reset, then release it on a rising edge
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // Reset value must read back as 512; start an image at that side with
    // all-ones pixels, which land in line store entries 0 and 1.
    apb_access(1'b0, '0);
    repeat (4) push_pixel(32'hFFFF_FFFF);
    settle();
    // Shrink to 1 in the middle of the first row: the column counter is already
    // past the new last position and wraps; the odd row then meets the ones above.
    set_side(10'd1);
    push_pixel(32'h5A3C_96E1);
    push_pixel(32'h0FF0_33CC);
    push_pixel(32'hFFFF_FFFF);
    push_pixel(32'hFFFF_FFFF);
    settle();
    images++;
    // A side of zero behaves as one; all-zero block gives all-zero average.
    set_side(10'd0);
    repeat (4) push_pixel(32'h0000_0000);
    settle();
    images++;
    // 1023 clamps to the maximum side; then shrink mid-row again, with byte
    // values chosen so that the floor of the mean really truncates.
    set_side(10'd1023);
    push_pixel(32'h80FF_0001);
    push_pixel(32'h7F00_0102);
    push_pixel(32'h1234_5678);
    push_pixel(32'hEDCB_A987);
    settle();
    set_side(10'd1);
    push_pixel(32'hC3A5_0F01);
    push_pixel(32'h3C5A_F0FE);
    push_pixel(32'h01FF_FF03);
    push_pixel(32'h0001_0203);
    settle();
    images++;
    directed_px = sent_px;

    // ---- random part ----
    // Whole images of random side, mostly small. About one in four is cut short,
    // the side is shrunk while the block is idle, and the image is finished
    // under the new side.
    while (sent_px < directed_px + RANDOM_PX) begin
      side = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
      // keep the last image from running far past the pixel budget
      while (side > 1 && 4 * side * side > directed_px + RANDOM_PX - sent_px) side--;
      set_side(10'(side));
      total = 4 * side * side;
      if ($urandom_range(0, 3) == 0) begin
        done = $urandom_range(1, total - 1);
        send_pixels(done);
        settle();
        wr_side = 10'($urandom_range(0, side));
        shrunk  = (wr_side == 0) ? 1 : int'(wr_side);
        set_side(wr_side);
        send_pixels(pixels_to_close(done, side, shrunk));
      end else begin
        send_pixels(total);
      end
      settle();
      images++;
    end

    apb_access(1'b0, '0);
    repeat (4) @(posedge clk);

    $display("Sent %0d source pixels (%0d directed) over %0d images; %0d output pixels checked.",
             sent_px, directed_px, images, checked);
    $display("Sides covered: reset 512, 0, 1, 1023 clamped, random 1..12, shrinks mid-image.");
    if (fail_count == 0 && pending == 0) begin
      $display("rgba_half_downsample_2x2 regression: pass");
    end else begin
      $display("rgba_half_downsample_2x2 regression: fail");
    end
    $finish;
  end

endmodule
